// ===== hdl/vad_pkg.sv =====
// Shared types and constants for the vector angle unit.
// Holds the CORDIC coordinate and angle formats, the arctangent table and the pipeline payload.
// No dependencies.
`default_nettype none

package vad_pkg;

    // Coordinates are scaled so that a full-scale input has magnitude 2^(COORD_TOP-1).
    localparam int COORD_TOP = 41;
    // Signed coordinate width: 2^40 input magnitude grows by at most 1.65 * sqrt(2).
    localparam int COORD_W   = 44;
    // Angle accumulator: degrees scaled by 2^ACC_FRAC, signed.
    localparam int ACC_FRAC  = 20;
    localparam int ACC_W     = 31;
    // Width of the wrapped and rounded accumulator, which stays below 2^29.
    localparam int RND_W     = 29;
    // Number of entries in the arctangent table.
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180 * (2 ** ACC_FRAC));
    localparam logic signed [ACC_W-1:0] FULL_TURN = ACC_W'(360 * (2 ** ACC_FRAC));

    // Axis on which the vector lies exactly; the zero vector counts as the +x axis.
    typedef enum logic [1:0] {
        AXIS_POS_X,
        AXIS_POS_Y,
        AXIS_NEG_X,
        AXIS_NEG_Y
    } axis_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ACC_W-1:0]   z;
        logic                      on_axis;
        axis_t                     axis;
    } cordic_t;

    // atan(2^-i) in degrees times 2^20, rounded to nearest.
    function automatic logic signed [ACC_W-1:0] atan_deg(input int idx);
        logic signed [ACC_W-1:0] val;
        case (idx)
            0:       val = ACC_W'(47185920);
            1:       val = ACC_W'(27855475);
            2:       val = ACC_W'(14718068);
            3:       val = ACC_W'(7471121);
            4:       val = ACC_W'(3750058);
            5:       val = ACC_W'(1876857);
            6:       val = ACC_W'(938658);
            7:       val = ACC_W'(469357);
            8:       val = ACC_W'(234682);
            9:       val = ACC_W'(117342);
            10:      val = ACC_W'(58671);
            11:      val = ACC_W'(29335);
            12:      val = ACC_W'(14668);
            13:      val = ACC_W'(7334);
            14:      val = ACC_W'(3667);
            15:      val = ACC_W'(1833);
            16:      val = ACC_W'(917);
            17:      val = ACC_W'(458);
            18:      val = ACC_W'(229);
            19:      val = ACC_W'(115);
            20:      val = ACC_W'(57);
            21:      val = ACC_W'(29);
            22:      val = ACC_W'(14);
            23:      val = ACC_W'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vad_prep.sv =====
// Input stage of the vector angle unit: axis detection and quadrant pre-rotation.
// Depends on vad_pkg.
`default_nettype none

module vad_prep
    import vad_pkg::*;
#(
    parameter int INPUT_WIDTH = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [INPUT_WIDTH-1:0] x_component,
    input  wire logic signed [INPUT_WIDTH-1:0] y_component,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cordic_t                            out_beat
);

    localparam int SCALE_SHIFT = COORD_TOP - INPUT_WIDTH;

    logic                      valid_reg;
    cordic_t                   data_reg;
    cordic_t                   data_next;
    logic signed [COORD_W-1:0] x_ext;
    logic signed [COORD_W-1:0] y_ext;
    logic                      x_zero;
    logic                      y_zero;
    logic                      left_half;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = data_reg;

    always_comb
    begin
        x_ext     = COORD_W'(x_component);
        y_ext     = COORD_W'(y_component);
        x_zero    = (x_component == '0);
        y_zero    = (y_component == '0);
        left_half = x_component[INPUT_WIDTH-1];

        data_next.on_axis = x_zero || y_zero;
        if (y_zero && !left_half)
            data_next.axis = AXIS_POS_X;
        else if (y_zero)
            data_next.axis = AXIS_NEG_X;
        else if (y_component[INPUT_WIDTH-1])
            data_next.axis = AXIS_NEG_Y;
        else
            data_next.axis = AXIS_POS_Y;

        // The left half-plane is turned by 180 degrees so the CORDIC sees x >= 0.
        if (left_half)
        begin
            data_next.x = (-x_ext) <<< SCALE_SHIFT;
            data_next.y = (-y_ext) <<< SCALE_SHIFT;
            data_next.z = HALF_TURN;
        end
        else
        begin
            data_next.x = x_ext <<< SCALE_SHIFT;
            data_next.y = y_ext <<< SCALE_SHIFT;
            data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/vad_cordic_stage.sv =====
// One registered CORDIC vectoring iteration of the vector angle unit.
// Depends on vad_pkg.
`default_nettype none

module vad_cordic_stage
    import vad_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire cordic_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cordic_t      out_beat
);

    localparam logic signed [ACC_W-1:0] ATAN_STEP = atan_deg(STAGE);

    logic                      valid_reg;
    cordic_t                   data_reg;
    cordic_t                   data_next;
    logic signed [COORD_W-1:0] x_shr;
    logic signed [COORD_W-1:0] y_shr;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = data_reg;

    always_comb
    begin
        x_shr     = in_data.x >>> STAGE;
        y_shr     = in_data.y >>> STAGE;
        data_next = in_data;
        // Rotate toward the x axis: clockwise while y is non-negative.
        if (!in_data.y[COORD_W-1])
        begin
            data_next.x = in_data.x + y_shr;
            data_next.y = in_data.y - x_shr;
            data_next.z = in_data.z + ATAN_STEP;
        end
        else
        begin
            data_next.x = in_data.x - y_shr;
            data_next.y = in_data.y + x_shr;
            data_next.z = in_data.z - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/vad_finish.sv =====
// Output stages of the vector angle unit: wrap to a positive angle, round, fold 360 to 0,
// and substitute exact axis angles. Two register stages. Depends on vad_pkg.
`default_nettype none

module vad_finish
    import vad_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire cordic_t                      in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [9+ANGLE_FRAC_BITS-1:0]      angle
);

    localparam int OUT_W = 9 + ANGLE_FRAC_BITS;
    localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(2 ** (SH - 1));
    localparam logic [OUT_W-1:0] ANGLE_90   = OUT_W'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [OUT_W-1:0] ANGLE_180  = OUT_W'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [OUT_W-1:0] ANGLE_270  = OUT_W'(270 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [OUT_W-1:0] ANGLE_360  = OUT_W'(360 * (2 ** ANGLE_FRAC_BITS));

    typedef struct packed {
        logic [RND_W-1:0] sum;
        logic             on_axis;
        axis_t            axis;
    } round_t;

    logic                    rnd_valid_reg;
    logic                    rnd_ready;
    round_t                  rnd_reg;
    round_t                  rnd_next;
    logic signed [ACC_W-1:0] wrapped;

    logic                    out_valid_reg;
    logic [OUT_W-1:0]        angle_reg;
    logic [OUT_W-1:0]        angle_next;
    logic [OUT_W-1:0]        quot;

    assign in_ready  = !rnd_valid_reg || rnd_ready;
    assign rnd_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

    // Stage one: bring the angle into [0, 360) and add half an output LSB.
    always_comb
    begin
        if (in_data.z[ACC_W-1])
            wrapped = in_data.z + FULL_TURN;
        else
            wrapped = in_data.z;
        rnd_next.sum     = RND_W'(wrapped) + ROUND_HALF;
        rnd_next.on_axis = in_data.on_axis;
        rnd_next.axis    = in_data.axis;
    end

    // Stage two: truncate, fold a full turn to zero, or take the exact axis angle.
    always_comb
    begin
        quot = rnd_reg.sum[RND_W-1:SH];
        if (rnd_reg.on_axis)
        begin
            case (rnd_reg.axis)
                AXIS_POS_X: angle_next = '0;
                AXIS_POS_Y: angle_next = ANGLE_90;
                AXIS_NEG_X: angle_next = ANGLE_180;
                AXIS_NEG_Y: angle_next = ANGLE_270;
                default:    angle_next = '0;
            endcase
        end
        else if (quot >= ANGLE_360)
            angle_next = quot - ANGLE_360;
        else
            angle_next = quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                rnd_valid_reg <= in_valid;
            if (rnd_ready)
                out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            rnd_reg <= rnd_next;
        if (rnd_valid_reg && rnd_ready)
            angle_reg <= angle_next;
    end

endmodule

`default_nettype wire

// ===== hdl/vector_angle_degrees_unit.sv =====
// Top level of the vector angle unit: a pipelined CORDIC that turns (x, y) into degrees.
// Depends on vad_pkg, vad_prep, vad_cordic_stage and vad_finish.
//
// Usage:
//   The slave stream takes one vector per beat: x_component and y_component, signed
//   two's complement. The master stream returns one beat per vector with its direction
//   in degrees, counter-clockwise from +x, as unsigned fixed point with ANGLE_FRAC_BITS
//   fraction bits, in [0, 360). Exact axis vectors give 0, 90, 180 or 270; (0, 0) gives 0.
//   An accepted input beat reaches its output beat through one pre-rotation stage,
//   one stage per CORDIC iteration, and two stages for wrapping, rounding and axis
//   substitution. Throughput is one beat per cycle while m_tready is high; every
//   stage is a register with its own valid bit.
//   Reset clears all valid bits, so the pipeline comes up empty and s_tready is high.
//   When the receiver holds m_tready low, the result stays on m_tdata and each stage
//   keeps taking beats while it has a free slot, so bubbles close up before
//   s_tready drops. Nothing is lost or repeated across a stall.
//   The ready path runs combinationally from m_tready back through every stage.
`default_nettype none

module vector_angle_degrees_unit
    import vad_pkg::*;
#(
    parameter int INPUT_WIDTH     = 12,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int CORDIC_STAGES   = 16
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            s_tvalid,
    output logic                                                 s_tready,
    // Fields from bit 0 up: x_component, y_component, zero padding.
    input  wire logic [((2*INPUT_WIDTH+7)/8)*8-1:0]              s_tdata,
    output logic                                                 m_tvalid,
    input  wire logic                                            m_tready,
    // Fields from bit 0 up: angle, zero padding.
    output logic [((9+ANGLE_FRAC_BITS+7)/8)*8-1:0]               m_tdata
);

    localparam int OUT_W    = 9 + ANGLE_FRAC_BITS;
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

    logic signed [INPUT_WIDTH-1:0] x_component;
    logic signed [INPUT_WIDTH-1:0] y_component;
    logic [OUT_W-1:0]              angle;

    // Stage k carries the item after k CORDIC iterations; stage 0 is the pre-rotation output.
    cordic_t stage_data  [CORDIC_STAGES+1];
    logic    stage_valid [CORDIC_STAGES+1];
    logic    stage_ready [CORDIC_STAGES+1];

    assign x_component = s_tdata[INPUT_WIDTH-1:0];
    assign y_component = s_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH];
    assign m_tdata     = M_DATA_W'(angle);

    vad_prep #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .x_component (x_component),
        .y_component (y_component),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_beat    (stage_data[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_iter
        vad_cordic_stage #(
            .STAGE (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_beat  (stage_data[k+1])
        );
    end

    vad_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[CORDIC_STAGES]),
        .in_ready  (stage_ready[CORDIC_STAGES]),
        .in_data   (stage_data[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .angle     (angle)
    );

endmodule

`default_nettype wire

// ===== verif/vector_angle_degrees_unit_test.sv =====
// Self-checking testbench for vector_angle_degrees_unit, the pipelined CORDIC angle unit.
// Drives vectors on the slave stream, predicts each angle and checks the master stream beats.
// Depends only on the RTL of the unit and its package.
`timescale 1ns / 1ps

module vector_angle_degrees_unit_test;

    localparam int COMP_W      = 12;
    localparam int FRAC_BITS   = 6;
    localparam int STAGES      = 16;
    localparam int ANGLE_W     = 9 + FRAC_BITS;
    localparam int S_DATA_W    = ((2 * COMP_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((ANGLE_W + 7) / 8) * 8;
    localparam int LATENCY     = STAGES + 3;
    localparam int DEGREE      = 1 << FRAC_BITS;
    localparam int SCALE_SHIFT = 41 - COMP_W;
    localparam int Z_FRAC      = 20;
    localparam int ROUND_SHIFT = Z_FRAC - FRAC_BITS;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // Fields from bit 0 up: x_component, y_component, zero padding.
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // Fields from bit 0 up: angle, zero padding.
    logic [M_DATA_W-1:0] m_tdata;

    // Angles still owed by the unit, oldest first.
    logic [ANGLE_W-1:0] pending_angles [$];
    int mismatch_count = 0;

    // Idling controls shared by the stimulus tasks and the receiver process.
    bit sender_steady = 1'b0;
    bit receiver_steady = 1'b0;
    bit hold_off_request = 1'b0;

    // atan(2^-i) in degrees with 20 fraction bits, rounded to nearest.
    longint atan_step_deg [16] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833
    };

    vector_angle_degrees_unit #(
        .INPUT_WIDTH     (COMP_W),
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .CORDIC_STAGES   (STAGES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Direction of (x, y) in degrees times 64, computed the same way the hardware does:
    // axis vectors are substituted, the left half-plane is folded over with a 180
    // degree offset, and the rest runs through a 16-stage vectoring CORDIC.
    function automatic logic [ANGLE_W-1:0] predict_direction(
        input logic signed [COMP_W-1:0] x_in,
        input logic signed [COMP_W-1:0] y_in
    );
        longint x;
        longint y;
        longint z;
        longint base;
        longint x_step;
        longint y_step;
        longint rounded;
        int stage;
        x = x_in;
        y = y_in;
        z = 0;
        base = 0;
        if (y == 0 && x >= 0)
            return '0;
        if (x == 0 && y > 0)
            return ANGLE_W'(90 * DEGREE);
        if (y == 0 && x < 0)
            return ANGLE_W'(180 * DEGREE);
        if (x == 0 && y < 0)
            return ANGLE_W'(270 * DEGREE);
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = longint'(180) << Z_FRAC;
        end
        x = x << SCALE_SHIFT;
        y = y << SCALE_SHIFT;
        for (stage = 0; stage < STAGES; stage++)
        begin
            // Arithmetic shifts of signed values round toward minus infinity.
            x_step = x >>> stage;
            y_step = y >>> stage;
            if (y >= 0)
            begin
                x = x + y_step;
                y = y - x_step;
                z = z + atan_step_deg[stage];
            end
            else
            begin
                x = x - y_step;
                y = y + x_step;
                z = z - atan_step_deg[stage];
            end
        end
        z = base + z;
        if (z < 0)
            z = z + (longint'(360) << Z_FRAC);
        rounded = (z + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        // A result that rounds up to a full turn wraps to zero.
        if (rounded >= 360 * DEGREE)
            rounded = rounded - 360 * DEGREE;
        return rounded[ANGLE_W-1:0];
    endfunction

    // Offers one vector and waits for its handshake, then idles the slave side about
    // 30 times in a hundred unless the sender is steady.
    task automatic send_vector(input logic [COMP_W-1:0] x_val, input logic [COMP_W-1:0] y_val);
        int gap;
        s_tdata  <= S_DATA_W'({y_val, x_val});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (!sender_steady && $urandom_range(99, 0) < 30)
        begin
            gap = $urandom_range(2, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Vectors exactly on an axis, including the zero vector, at unit and full length.
    task automatic test_axis_vectors;
        send_vector(12'sd0, 12'sd0);
        send_vector(12'sd1, 12'sd0);
        send_vector(12'sd2047, 12'sd0);
        send_vector(12'sd0, 12'sd1);
        send_vector(12'sd0, 12'sd2047);
        send_vector(-12'sd1, 12'sd0);
        send_vector(-12'sd2048, 12'sd0);
        send_vector(12'sd0, -12'sd1);
        send_vector(12'sd0, -12'sd2048);
    endtask

    // Diagonals, full-scale corners and vectors just off an axis. Just below the +x
    // axis the angle sums negative and needs the full turn added; just off the -x axis
    // the vector is folded over with the half turn.
    task automatic test_corner_vectors;
        send_vector(12'sd2047, 12'sd2047);
        send_vector(-12'sd2048, -12'sd2048);
        send_vector(-12'sd2048, 12'sd2047);
        send_vector(12'sd2047, -12'sd2048);
        send_vector(12'sd1, 12'sd1);
        send_vector(-12'sd1, 12'sd1);
        send_vector(-12'sd1, -12'sd1);
        send_vector(12'sd1, -12'sd1);
        send_vector(12'sd2047, 12'sd1);
        send_vector(12'sd2047, -12'sd1);
        send_vector(-12'sd2048, 12'sd1);
        send_vector(-12'sd2048, -12'sd1);
        send_vector(12'sd1, 12'sd2047);
        send_vector(-12'sd1, -12'sd2048);
    endtask

    // Random vectors with random idling on both sides. Most are uniform over the
    // full range; the rest are short vectors and vectors hugging an axis, where
    // the quadrant folding and the axis checks matter most.
    task automatic test_random_vectors(input int count);
        logic [COMP_W-1:0] x_val;
        logic [COMP_W-1:0] y_val;
        int kind;
        repeat (count)
        begin
            kind  = $urandom_range(9, 0);
            x_val = COMP_W'($urandom);
            y_val = COMP_W'($urandom);
            if (kind == 0)
            begin
                x_val = COMP_W'($signed($urandom_range(16, 0)) - 8);
                y_val = COMP_W'($signed($urandom_range(16, 0)) - 8);
            end
            else if (kind == 1)
                y_val = COMP_W'($signed($urandom_range(4, 0)) - 2);
            else if (kind == 2)
                x_val = COMP_W'($signed($urandom_range(4, 0)) - 2);
            send_vector(x_val, y_val);
        end
    endtask

    // A stretch of back-to-back beats with neither side idling.
    task automatic test_steady_stream(input int count);
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        test_random_vectors(count);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // beats, so the pipeline fills and the unit has to stall its input.
    task automatic test_output_stall(input int count);
        hold_off_request = 1'b1;
        sender_steady    = 1'b1;
        test_random_vectors(count);
        sender_steady    = 1'b0;
    endtask

    // Master-side ready: random idling, a steady mode, and a long hold-off that
    // is counted here once requested.
    initial
    begin : receiver_process
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (receiver_steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99, 0) >= 30);
        end
    end

    // Every accepted input beat queues its predicted angle; every accepted output
    // beat is checked against the oldest one.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_angles.push_back(predict_direction(s_tdata[COMP_W-1:0],
                                                       s_tdata[2*COMP_W-1:COMP_W]));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_angles.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected angle beat, actual %0d", $time,
                         m_tdata[ANGLE_W-1:0]);
            end
            else if (m_tdata[ANGLE_W-1:0] !== pending_angles[0])
            begin
                mismatch_count++;
                $display("%0t: angle mismatch, expected %0d actual %0d", $time,
                         pending_angles[0], m_tdata[ANGLE_W-1:0]);
                void'(pending_angles.pop_front());
            end
            else
                void'(pending_angles.pop_front());
        end
    end

    initial
    begin : main_sequence
        int wait_cycles;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axis_vectors();
        test_corner_vectors();
        test_random_vectors(220);
        test_steady_stream(60);
        test_output_stall(60);
        test_random_vectors(40);
        s_tvalid <= 1'b0;

        // Let the pipeline drain, then wait out its latency to catch stray beats.
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (pending_angles.size() != 0 && wait_cycles < DRAIN_LIMIT);
        repeat (LATENCY + 4) @(posedge clk);
        if (pending_angles.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d angles never arrived, next expected %0d", $time,
                     pending_angles.size(), pending_angles[0]);
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
